>>> src/zba_pkg.sv
// zone bitmap allocator: shared constants, codes and control types
// no dependencies; imported by every module of the block
`default_nettype none

package zba_pkg;

  localparam int MAP_BITS  = 8192;
  localparam int WORD_BITS = 32;
  localparam int MAP_WORDS = MAP_BITS / WORD_BITS;
  localparam int WIDX_W    = $clog2(MAP_WORDS);
  localparam int POS_W     = $clog2(WORD_BITS);
  localparam int BIT_W     = $clog2(MAP_BITS);

  localparam int ZONE_W = 16;
  localparam int STAT_W = 2;
  localparam int IDX_W  = 8;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 16;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFREE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  localparam logic CFG_FIRST_ZONE = 1'b0;
  localparam logic CFG_ZONE_COUNT = 1'b1;

  typedef struct packed {
    logic load;
    logic start;
    logic scan;
    logic push;
  } zba_cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
    logic slot_free;
  } zba_stat_t;

endpackage

`default_nettype wire

>>> src/zone_bitmap_allocator_top.sv
// zone bitmap allocator: top level, joins controller and datapath
// depends on zba_pkg, zba_ctrl, zba_datapath
//
//   port group  dir  contents
//   in_*        in   item: tuser func, tdata word_index and word_data
//   out_*       out  item: tdata zone, tuser status
//   cfg_*       in   register writes: 0 first_data_zone, 1 data_zone_count
//
// a load item goes through the result state to the output register; an
// allocation scans words up to the one that holds the limit, at most 256,
// with one bitmap word read per cycle from the memory
// reset clears the word valid flags at once, so no clearing pass runs
// a waiting result holds in the output register while the next item is taken
`default_nettype none

module zone_bitmap_allocator_top
  import zba_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // word_index [7:0], word_data [39:8]
  input  wire logic [0:0]  in_tuser,   // func [0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // zone [15:0]
  output logic [1:0]       out_tuser,  // status [1:0]
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  zba_cmd_t  cmd;
  zba_stat_t stat;

  zba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_func  (in_tuser[0]),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  zba_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_word_index (in_tdata[IDX_W-1:0]),
    .in_word_data  (in_tdata[IDX_W+DATA_W-1:IDX_W]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_zone      (out_tdata),
    .out_status    (out_tuser)
  );

endmodule

`default_nettype wire

>>> src/zba_ctrl.sv
// zone bitmap allocator: controller state machine
// depends on zba_pkg; drives the datapath by command and reads its status
`default_nettype none

module zba_ctrl
  import zba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_func,
  output logic           in_ready,
  input  wire zba_stat_t stat,
  output zba_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == FUNC_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = S_RESULT;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit || stat.exhausted) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat.slot_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/zba_datapath.sv
// zone bitmap allocator: bitmap memory, config registers, scan and result logic
// depends on zba_pkg; commanded by zba_ctrl
`default_nettype none

module zba_datapath
  import zba_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire zba_cmd_t          cmd,
  output zba_stat_t              stat,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic [IDX_W-1:0]  in_word_index,
  input  wire logic [DATA_W-1:0] in_word_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ZONE_W-1:0]      out_zone,
  output logic [STAT_W-1:0]      out_status
);

  typedef logic [WORD_BITS-1:0] word_t;

  function automatic logic [POS_W-1:0] lowest_set(input word_t v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) p = POS_W'(i);
    end
    return p;
  endfunction

  word_t mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] map_vld_r;

  logic [CFG_W-1:0]  first_zone_r;
  logic [CFG_W-1:0]  zone_count_r;

  logic [WIDX_W-1:0] last_w_r;
  logic [POS_W-1:0]  lim_pos_r;
  logic [WIDX_W:0]   widx_r;
  logic [WIDX_W-1:0] cidx_r;
  logic              dv_r;
  word_t             rd_data_r;
  logic              rd_vld_r;

  logic [ZONE_W-1:0] res_zone_r;
  logic [STAT_W-1:0] res_status_r;
  logic              out_valid_r;
  logic [ZONE_W-1:0] out_zone_r;
  logic [STAT_W-1:0] out_status_r;

  logic [CFG_W-1:0]  lim;
  logic              issue;
  word_t             word_eff;
  word_t             tail;
  word_t             free;
  logic              any_free;
  logic [POS_W-1:0]  pos;
  logic [BIT_W-1:0]  bit_num;
  logic [ZONE_W:0]   zsum;
  logic              bad_zone;
  logic              load_ok;
  logic              wb;
  logic              we;
  logic [WIDX_W-1:0] wa;
  word_t             wd;

  // search limit clamped to the map
  assign lim = (zone_count_r > CFG_W'(MAP_BITS - 1)) ? CFG_W'(MAP_BITS - 1) : zone_count_r;

  assign issue    = cmd.scan && (widx_r <= {1'b0, last_w_r});
  assign word_eff = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      tail[i] = (cidx_r == last_w_r) && (POS_W'(i) > lim_pos_r);
    end
  end

  assign free     = ~(word_eff | tail);
  assign any_free = |free;
  assign pos      = lowest_set(free);
  assign bit_num  = {cidx_r, pos};
  assign zsum     = {1'b0, first_zone_r} + (ZONE_W + 1)'(bit_num) - (ZONE_W + 1)'(1);
  assign bad_zone = (bit_num == '0) || zsum[ZONE_W];

  assign stat.hit       = dv_r && any_free;
  assign stat.exhausted = dv_r && !any_free && (cidx_r == last_w_r);
  assign stat.slot_free = !out_valid_r || out_ready;

  assign load_ok = cmd.load && (32'(in_word_index) < 32'(MAP_WORDS));
  assign wb      = cmd.scan && stat.hit;
  assign we      = load_ok || wb;
  assign wa      = wb ? cidx_r : WIDX_W'(in_word_index);
  assign wd      = wb ? (word_eff | (word_t'(1) << pos)) : WORD_BITS'(in_word_data);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (issue) begin
      rd_data_r <= mem[widx_r[WIDX_W-1:0]];
      rd_vld_r  <= map_vld_r[widx_r[WIDX_W-1:0]];
      cidx_r    <= widx_r[WIDX_W-1:0];
    end
    if (cmd.start) begin
      last_w_r  <= lim[BIT_W-1:POS_W];
      lim_pos_r <= lim[POS_W-1:0];
    end
    if (cmd.load) begin
      res_zone_r   <= '0;
      res_status_r <= ST_OK;
    end else if (wb) begin
      res_zone_r   <= bad_zone ? '0 : zsum[ZONE_W-1:0];
      res_status_r <= bad_zone ? ST_INVALID : ST_OK;
    end else if (cmd.scan && stat.exhausted) begin
      res_zone_r   <= '0;
      res_status_r <= ST_NOFREE;
    end
    if (cmd.push) begin
      out_zone_r   <= res_zone_r;
      out_status_r <= res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_vld_r    <= '0;
      first_zone_r <= '0;
      zone_count_r <= '0;
      widx_r       <= '0;
      dv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (we) begin
        map_vld_r[wa] <= 1'b1;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_FIRST_ZONE) begin
          first_zone_r <= cfg_wdata;
        end else begin
          zone_count_r <= cfg_wdata;
        end
      end
      if (cmd.start) begin
        widx_r <= '0;
        dv_r   <= 1'b0;
      end else if (cmd.scan) begin
        dv_r <= issue;
        if (issue) begin
          widx_r <= widx_r + (WIDX_W + 1)'(1);
        end
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_zone   = out_zone_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

>>> tb/sv/tb_zone_bitmap_allocator_top.sv
// self-checking bench for zone_bitmap_allocator_top: directed reset, zone-limit and full-map
// cases, then random load/allocate traffic under varying stream idling and register settings
// depends on zba_pkg and zone_bitmap_allocator_top
module tb_zone_bitmap_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import zba_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int PHASE_ITEMS    = 130;

  typedef struct packed {
    logic [ZONE_W-1:0] zone;
    logic [STAT_W-1:0] status;
  } alloc_result_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata   = '0;  // word_index [7:0], word_data [39:8]
  logic [0:0]        in_tuser   = '0;  // func [0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;        // zone [15:0]
  logic [1:0]        out_tuser;        // status [1:0]
  logic              cfg_we     = 1'b0;
  logic              cfg_index  = CFG_FIRST_ZONE;
  logic [CFG_W-1:0]  cfg_wdata  = '0;

  logic [WORD_BITS-1:0] zone_map [MAP_WORDS];
  logic [CFG_W-1:0]     first_zone;
  logic [CFG_W-1:0]     zone_count;
  alloc_result_t        pending_results [$];
  alloc_result_t        head_result;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int items_sent     = 0;
  int results_checked = 0;
  int ok_count       = 0;
  int nofree_count   = 0;
  int invalid_count  = 0;
  int quiet_cycles   = 0;

  zone_bitmap_allocator_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic alloc_result_t predict_result(input logic func,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic [DATA_W-1:0] data);
    alloc_result_t     res;
    int unsigned       last_bit;
    int unsigned       zone_num;
    logic [WIDX_W-1:0] w;
    logic [POS_W-1:0]  p;
    res.zone   = '0;
    res.status = ST_OK;
    if (func == FUNC_LOAD) begin
      zone_map[idx] = data[WORD_BITS-1:0];
      return res;
    end
    last_bit   = (zone_count > MAP_BITS - 1) ? MAP_BITS - 1 : zone_count;
    res.status = ST_NOFREE;
    for (int unsigned b = 0; b <= last_bit; b++) begin
      w = WIDX_W'(b / WORD_BITS);
      p = POS_W'(b % WORD_BITS);
      if (!zone_map[w][p]) begin
        zone_map[w][p] = 1'b1;
        zone_num = b + first_zone - 1;
        if (b == 0 || zone_num > 16'hFFFF) begin
          res.status = ST_INVALID;
        end else begin
          res.status = ST_OK;
          res.zone   = zone_num[ZONE_W-1:0];
        end
        return res;
      end
    end
    return res;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic send_item(input logic func, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {data, idx};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_result(func, idx, data));
    items_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic configure(input logic [CFG_W-1:0] first, input logic [CFG_W-1:0] count);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIRST_ZONE;
    cfg_wdata <= first;
    @(posedge clk);
    cfg_index <= CFG_ZONE_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we     <= 1'b0;
    first_zone  = first;
    zone_count  = count;
  endtask

  // registers at reset: only bit 0 is in range
  task automatic test_reset_state();
    send_item(FUNC_ALLOC, '0, '0);
    send_item(FUNC_ALLOC, '1, '1);
    send_item(FUNC_LOAD, 8'd0, 32'h0000_0000);
    send_item(FUNC_ALLOC, 8'd0, 32'h0000_0000);
  endtask

  task automatic test_zone_limits();
    configure(16'hFFFF, 16'hFFFF);
    send_item(FUNC_ALLOC, '0, '0);
    send_item(FUNC_ALLOC, '0, '0);
    send_item(FUNC_LOAD, 8'd0, 32'h7FFF_FFFF);
    configure(16'd10, 16'd31);
    send_item(FUNC_ALLOC, '0, '0);
    send_item(FUNC_ALLOC, '0, '0);
    configure(16'd10, 16'd32);
    send_item(FUNC_ALLOC, '0, '0);
    send_item(FUNC_LOAD, 8'd255, 32'hFFFF_FFFF);
    send_item(FUNC_LOAD, 8'd254, 32'h0000_0000);
    send_item(FUNC_ALLOC, '0, '0);
  endtask

  // fill every word, leave only the top map bit free, exhaust it, then free one bit in word 128 and take it
  task automatic test_full_map();
    configure(16'd100, 16'hFFFF);
    for (int w = 0; w < MAP_WORDS; w++) begin
      send_item(FUNC_LOAD, w[IDX_W-1:0], (w == MAP_WORDS - 1) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF);
    end
    wait_idle();
    send_item(FUNC_ALLOC, '0, '0);
    send_item(FUNC_ALLOC, '0, '0);
    send_item(FUNC_LOAD, 8'd128, 32'hFFFF_FFFE);
    send_item(FUNC_ALLOC, '0, '0);
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0]  fz;
    logic [CFG_W-1:0]  zc;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
    int unsigned       span;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin fz = 16'd0;     zc = 16'hFFFF; end
        1: begin fz = 16'hFFFF;  zc = 16'd0;    end
        2: begin fz = 16'd1;     zc = 16'd8191; end
        3: begin fz = 16'd65500; zc = 16'd100;  end
        7: begin fz = CFG_W'($urandom()); zc = CFG_W'($urandom_range(8192, 65535)); end
        default: begin fz = CFG_W'($urandom()); zc = CFG_W'($urandom_range(0, 400)); end
      endcase
      configure(fz, zc);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 35) begin
          span = ((zone_count > MAP_BITS - 1) ? MAP_BITS - 1 : zone_count) / WORD_BITS;
          idx  = ($urandom_range(3) != 0) ? IDX_W'($urandom_range(span))
                                          : IDX_W'($urandom_range(MAP_WORDS - 1));
          case ($urandom_range(3))
            0: data = 32'hFFFF_FFFF;
            1: data = $urandom();
            2: data = $urandom() & $urandom();
            default: data = $urandom() | $urandom();
          endcase
          send_item(FUNC_LOAD, idx, data);
        end else begin
          send_item(FUNC_ALLOC, IDX_W'($urandom()), $urandom());
        end
        if ($urandom_range(39) == 0) wait_idle();
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result zone %0d status %0d", out_tdata, out_tuser));
      end else begin
        head_result = pending_results.pop_front();
        if (out_tdata !== head_result.zone || out_tuser !== head_result.status) begin
          flag_error($sformatf("result %0d: expected zone %0d status %0d, got zone %0d status %0d",
                               results_checked, head_result.zone, head_result.status,
                               out_tdata, out_tuser));
        end
      end
      results_checked++;
      case (out_tuser)
        ST_OK:      ok_count++;
        ST_NOFREE:  nofree_count++;
        ST_INVALID: invalid_count++;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("** zone_bitmap_allocator_top: FAILED **");
      $finish;
    end
  end

  initial begin
    foreach (zone_map[i]) zone_map[i] = '0;
    first_zone = '0;
    zone_count = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_zone_limits();
    test_full_map();
    test_random_traffic();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    end
    $display("%0d items sent, %0d results checked (status ok %0d, no free %0d, invalid %0d)",
             items_sent, results_checked, ok_count, nofree_count, invalid_count);
    $display("zone limits, full map scan and four idle/stall mixes over eight register settings");
    if (error_count == 0) begin
      $display("** zone_bitmap_allocator_top: PASSED **");
    end else begin
      $display("** zone_bitmap_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule
